// ----- design/bfs_pkg.sv -----
package bfs_pkg;

	// Storage geometry
	localparam int DEPTH = 128;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Command codes
	localparam logic [2:0] CMD_PUSH  = 3'd0;
	localparam logic [2:0] CMD_POP   = 3'd1;
	localparam logic [2:0] CMD_PEEK  = 3'd2;
	localparam logic [2:0] CMD_SEEK  = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] byte_value;
		logic [7:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] match_position;
		logic [7:0] fill_count;
		logic [1:0] status;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SEEK
	} state_t;

	// Step a ring pointer, wrapping from the last slot to zero
	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- design/byte_fifo_with_seek_top.sv -----
// Circular byte FIFO with delimiter search. Issue a command by raising start
// while busy is low; exactly one result comes back later on rsp, qualified by
// a single-cycle done strobe that must be captured on that cycle since the
// block cannot hold it. Push, clear, unused commands and a pop on an empty
// FIFO finish in the execute state; pop and peek pass through a read state
// because of the registered read port of the byte store RAM, and seek
// streams the held bytes out of the single RAM read port one per cycle,
// oldest first, and retires on the first match or once the last compare
// has missed (at once on an empty FIFO). Reset and clear zero the store
// at once through per-slot valid flags; no sweep is needed.
module byte_fifo_with_seek_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bfs_pkg::req_t req,
	output logic          done,
	output bfs_pkg::rsp_t rsp
);

	bfs_pkg::state_t state_q, state_d;
	bfs_pkg::req_t   req_q;

	logic [bfs_pkg::PTR_W-1:0] rp_q, rp_d;
	logic [bfs_pkg::PTR_W-1:0] wp_q, wp_d;
	logic [bfs_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [bfs_pkg::DEPTH-1:0] valid_q;

	// Seek scan state
	logic [bfs_pkg::PTR_W-1:0] cur_q;
	logic [bfs_pkg::CNT_W-1:0] issue_k_q;
	logic                      cmp_v_s1;
	logic [bfs_pkg::CNT_W-1:0] cmp_k_s1;
	logic                      valid_s1;

	// RAM port
	logic                      ram_we;
	logic [bfs_pkg::PTR_W-1:0] ram_waddr;
	logic [7:0]                ram_wdata;
	logic                      ram_re;
	logic [bfs_pkg::PTR_W-1:0] ram_raddr;
	logic [7:0]                ram_rdata;

	// Control from the output decode
	logic          fin;
	bfs_pkg::rsp_t rsp_d;
	logic          vset;
	logic          vclr;
	logic          vclr_all;
	logic          seek_init;
	logic          issue;
	logic          full;
	logic          empty;
	logic          in_range;
	logic [7:0]    rd_byte;

	bfs_ram #(
		.WIDTH(8),
		.DEPTH(bfs_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign full     = (cnt_q == bfs_pkg::CNT_W'(bfs_pkg::DEPTH));
	assign empty    = (cnt_q == '0);
	assign in_range = ({1'b0, req_q.slot_index} < 9'(bfs_pkg::DEPTH));
	assign rd_byte  = valid_s1 ? ram_rdata : 8'h00;
	assign issue    = (issue_k_q < cnt_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfs_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bfs_pkg::ST_EXEC;
				end
			end
			bfs_pkg::ST_EXEC: begin
				case (req_q.cmd)
					bfs_pkg::CMD_POP:  state_d = empty ? bfs_pkg::ST_IDLE : bfs_pkg::ST_READ;
					bfs_pkg::CMD_PEEK: state_d = bfs_pkg::ST_READ;
					bfs_pkg::CMD_SEEK: state_d = bfs_pkg::ST_SEEK;
					default:           state_d = bfs_pkg::ST_IDLE;
				endcase
			end
			bfs_pkg::ST_READ: state_d = bfs_pkg::ST_IDLE;
			bfs_pkg::ST_SEEK: begin
				if (fin) begin
					state_d = bfs_pkg::ST_IDLE;
				end
			end
			default: state_d = bfs_pkg::ST_IDLE;
		endcase
	end

	// Output decode: RAM accesses, pointer updates and the result
	always_comb begin
		ram_we               = 1'b0;
		ram_waddr            = wp_q;
		ram_wdata            = req_q.byte_value;
		ram_re               = 1'b0;
		ram_raddr            = rp_q;
		rp_d                 = rp_q;
		wp_d                 = wp_q;
		cnt_d                = cnt_q;
		vset                 = 1'b0;
		vclr                 = 1'b0;
		vclr_all             = 1'b0;
		seek_init            = 1'b0;
		fin                  = 1'b0;
		rsp_d.read_data      = 8'h00;
		rsp_d.match_position = 8'h00;
		rsp_d.status         = bfs_pkg::STAT_OK;
		case (state_q)
			bfs_pkg::ST_EXEC: begin
				case (req_q.cmd)
					bfs_pkg::CMD_PUSH: begin
						fin = 1'b1;
						if (full) begin
							rsp_d.status = bfs_pkg::STAT_FULL;
						end else begin
							ram_we = 1'b1;
							vset   = 1'b1;
							wp_d   = bfs_pkg::ptr_adv(wp_q);
							cnt_d  = cnt_q + 1'b1;
						end
					end
					bfs_pkg::CMD_POP: begin
						if (empty) begin
							fin          = 1'b1;
							rsp_d.status = bfs_pkg::STAT_EMPTY;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = rp_q;
						end
					end
					bfs_pkg::CMD_PEEK: begin
						ram_re    = 1'b1;
						ram_raddr = req_q.slot_index[bfs_pkg::PTR_W-1:0];
					end
					bfs_pkg::CMD_SEEK: begin
						seek_init = 1'b1;
					end
					bfs_pkg::CMD_CLEAR: begin
						fin      = 1'b1;
						vclr_all = 1'b1;
						rp_d     = '0;
						wp_d     = '0;
						cnt_d    = '0;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			bfs_pkg::ST_READ: begin
				fin = 1'b1;
				if (req_q.cmd == bfs_pkg::CMD_POP) begin
					rsp_d.read_data = rd_byte;
					vclr            = 1'b1;
					rp_d            = bfs_pkg::ptr_adv(rp_q);
					cnt_d           = cnt_q - 1'b1;
				end else begin
					rsp_d.read_data = in_range ? rd_byte : 8'h00;
				end
			end
			bfs_pkg::ST_SEEK: begin
				if (cmp_v_s1 && (rd_byte == req_q.byte_value)) begin
					fin                  = 1'b1;
					rsp_d.match_position = 8'(cmp_k_s1 + 1'b1);
				end else if (!issue && !cmp_v_s1) begin
					fin = 1'b1;
				end else begin
					ram_re    = issue;
					ram_raddr = cur_q;
				end
			end
			default: begin
			end
		endcase
		rsp_d.fill_count = 8'(cnt_d);
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfs_pkg::ST_IDLE;
			rp_q    <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			cnt_q   <= cnt_d;
			done    <= fin;
			if (vclr_all) begin
				valid_q <= '0;
			end else begin
				if (vset) begin
					valid_q[wp_q] <= 1'b1;
				end
				if (vclr) begin
					valid_q[rp_q] <= 1'b0;
				end
			end
		end
	end

	// Advance the seek scan and track the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1  <= 1'b0;
			issue_k_q <= '0;
			cur_q     <= '0;
		end else if (seek_init) begin
			cmp_v_s1  <= 1'b0;
			issue_k_q <= '0;
			cur_q     <= rp_q;
		end else if (state_q == bfs_pkg::ST_SEEK) begin
			cmp_v_s1 <= ram_re;
			if (ram_re) begin
				issue_k_q <= issue_k_q + 1'b1;
				cur_q     <= bfs_pkg::ptr_adv(cur_q);
			end
		end
	end

	// Capture the transaction, the read-side tags and the result
	always_ff @(posedge clk) begin
		if ((state_q == bfs_pkg::ST_IDLE) && start) begin
			req_q <= req;
		end
		if (ram_re) begin
			valid_s1 <= valid_q[ram_raddr];
			cmp_k_s1 <= issue_k_q;
		end
		if (fin) begin
			rsp <= rsp_d;
		end
	end

	assign busy = (state_q != bfs_pkg::ST_IDLE);

endmodule

// ----- design/bfs_ram.sv -----
module bfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- bench/bfs_checker.sv -----
`timescale 1ns / 1ps

// Watch the command and result channels, predict each result from a private
// copy of the FIFO state, and compare in order.
module bfs_checker
	import bfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	// Shadow copy of the ring and its pointers
	logic [7:0] ring [DEPTH];
	int         rd_idx;
	int         wr_idx;
	int         held;
	int         mismatches;
	rsp_t       expected_rsp_q [$];

	function automatic int ring_next(input int p);
		return (p + 1) % DEPTH;
	endfunction

	function automatic void wipe_ring();
		int i;
		for (i = 0; i < DEPTH; i++) begin
			ring[i] = 8'h00;
		end
		rd_idx = 0;
		wr_idx = 0;
		held   = 0;
	endfunction

	// Apply one command to the shadow state and return the result it yields
	function automatic rsp_t apply_cmd(input req_t r);
		rsp_t o;
		int   cur;
		int   k;
		bit   hit;
		o = '0;
		case (r.cmd)
			CMD_PUSH: begin
				if (held >= DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					ring[wr_idx] = r.byte_value;
					wr_idx = ring_next(wr_idx);
					held++;
				end
			end
			CMD_POP: begin
				if (held == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					o.read_data = ring[rd_idx];
					ring[rd_idx] = 8'h00;
					rd_idx = ring_next(rd_idx);
					held--;
				end
			end
			CMD_PEEK: begin
				if (int'(r.slot_index) < DEPTH) begin
					o.read_data = ring[r.slot_index];
				end
			end
			CMD_SEEK: begin
				// Scan from the oldest byte, wrapping at the end of the ring
				cur = rd_idx;
				hit = 1'b0;
				for (k = 0; k < held; k++) begin
					if (!hit && ring[cur] == r.byte_value) begin
						o.match_position = 8'(k + 1);
						hit = 1'b1;
					end
					cur = ring_next(cur);
				end
			end
			CMD_CLEAR: begin
				wipe_ring();
			end
			default: begin
			end
		endcase
		o.fill_count = 8'(held);
		return o;
	endfunction

	function automatic void cmp_field(input string fld, input logic [7:0] e,
			input logic [7:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, e, a);
			mismatches++;
		end
	endfunction

	// Retire results first, then record the transaction accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			wipe_ring();
			expected_rsp_q.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h", $time, rsp);
					mismatches++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					cmp_field("read_data", exp_rsp.read_data, rsp.read_data);
					cmp_field("match_position", exp_rsp.match_position, rsp.match_position);
					cmp_field("fill_count", exp_rsp.fill_count, rsp.fill_count);
					cmp_field("status", 8'(exp_rsp.status), 8'(rsp.status));
				end
			end
			if (start && !busy) begin
				expected_rsp_q.push_back(apply_cmd(req));
			end
			fail_count <= mismatches;
			pending    <= expected_rsp_q.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import bfs_pkg::*;

	// Commands with no effect
	localparam logic [2:0] CMD_NOP_FIRST = 3'd5;
	localparam logic [2:0] CMD_NOP_LAST  = 3'd7;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;
	int   fail_count;
	int   pending;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	byte_fifo_with_seek_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	bfs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic req_t mk_req(input logic [2:0] c, input logic [7:0] v,
			input logic [7:0] s);
		req_t r;
		r.cmd        = c;
		r.byte_value = v;
		r.slot_index = s;
		return r;
	endfunction

	// Favor a narrow alphabet so seeks hit often
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		if ($urandom_range(99) < 60) begin
			b = 8'($urandom_range(15));
		end else begin
			b = 8'($urandom_range(255));
		end
		return b;
	endfunction

	function automatic req_t rand_req(input int push_pct, input int pop_pct);
		int   roll;
		req_t r;
		r.cmd        = CMD_PEEK;
		r.byte_value = 8'($urandom_range(255));
		r.slot_index = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
		                                        : 8'($urandom_range(DEPTH - 1));
		roll = $urandom_range(99);
		if (roll < push_pct) begin
			r.cmd        = CMD_PUSH;
			r.byte_value = pick_byte();
		end else if (roll < push_pct + pop_pct) begin
			r.cmd = CMD_POP;
		end else begin
			roll = $urandom_range(99);
			if (roll < 40) begin
				r.cmd = CMD_PEEK;
			end else if (roll < 93) begin
				r.cmd        = CMD_SEEK;
				r.byte_value = pick_byte();
			end else if (roll < 98) begin
				r.cmd = 3'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
			end else begin
				r.cmd = CMD_CLEAR;
			end
		end
		return r;
	endfunction

	// Issue one transaction, optionally idling first, and hold until accepted
	task automatic send_cmd(input req_t r, input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every outstanding result has come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Alternate fill, drain and mixed stretches so the ring hits full and empty
	task automatic run_random(input int n_items, input int idle_pct);
		int sent;
		int seg_len;
		int push_pct;
		int pop_pct;
		int k;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(2))
				0: begin
					push_pct = 80;
					pop_pct  = 10;
					seg_len  = $urandom_range(150, 260);
				end
				1: begin
					push_pct = 10;
					pop_pct  = 75;
					seg_len  = $urandom_range(60, 180);
				end
				default: begin
					push_pct = 40;
					pop_pct  = 35;
					seg_len  = $urandom_range(30, 120);
				end
			endcase
			if ($urandom_range(9) == 0) begin
				wait_drained();
			end
			for (k = 0; k < seg_len && sent < n_items; k++) begin
				send_cmd(rand_req(push_pct, pop_pct), idle_pct);
				sent++;
			end
		end
	endtask

	initial begin
		logic [2:0] nop_cmd;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty FIFO: pop, seek and peeks at both ends of the index range
		send_cmd(mk_req(CMD_POP, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_SEEK, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_PEEK, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_PEEK, 8'h00, 8'(DEPTH - 1)), 0);
		send_cmd(mk_req(CMD_PEEK, 8'h00, 8'(DEPTH)), 0);
		send_cmd(mk_req(CMD_PEEK, 8'h00, 8'hFF), 0);

		// Extreme byte values, hits at several positions and a miss
		send_cmd(mk_req(CMD_PUSH, 8'hFF, 8'hFF), 0);
		send_cmd(mk_req(CMD_PUSH, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_PUSH, 8'hA5, 8'h00), 0);
		send_cmd(mk_req(CMD_SEEK, 8'hFF, 8'h00), 0);
		send_cmd(mk_req(CMD_SEEK, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_SEEK, 8'hA5, 8'h00), 0);
		send_cmd(mk_req(CMD_SEEK, 8'h5A, 8'h00), 0);

		// Pop, then peek the freed slot and one live slot
		send_cmd(mk_req(CMD_POP, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_PEEK, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_PEEK, 8'h00, 8'h02), 0);

		// Commands that do nothing
		for (nop_cmd = CMD_NOP_FIRST; nop_cmd != CMD_NOP_LAST; nop_cmd++) begin
			send_cmd(mk_req(nop_cmd, 8'hFF, 8'hFF), 0);
		end
		send_cmd(mk_req(CMD_NOP_LAST, 8'hFF, 8'hFF), 0);

		// Clear with data held, then reuse
		send_cmd(mk_req(CMD_CLEAR, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_PEEK, 8'h00, 8'h01), 0);
		send_cmd(mk_req(CMD_SEEK, 8'hA5, 8'h00), 0);
		send_cmd(mk_req(CMD_PUSH, 8'h5A, 8'h00), 0);
		send_cmd(mk_req(CMD_POP, 8'h00, 8'h00), 0);
		send_cmd(mk_req(CMD_POP, 8'h00, 8'h00), 0);
		wait_drained();

		// Random traffic under three idling profiles
		run_random(700, 30);
		wait_drained();
		run_random(700, 68);
		wait_drained();
		run_random(500, 0);
		wait_drained();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/bfs_pkg.sv
design/bfs_ram.sv
design/byte_fifo_with_seek_top.sv
bench/bfs_checker.sv
bench/tb.sv
